// File: rtl/assert_macros.svh
// Shared assertion shorthands; every property is clocked on clock and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CPR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cpr assertion failed");

// Next-cycle implication
`define CPR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cpr assertion failed");

`endif

// File: rtl/cpr_pkg.sv
package cpr_pkg;

   // Geometry
   localparam int DOTS_PER_ROW = 1280;
   localparam int MIN_SWEEP    = 64;

   // Field and datapath widths
   localparam int TIME_W = 48;
   localparam int ROWS_W = 16;
   localparam int COL_W  = 12;
   localparam int REV_W  = 32;
   localparam int CFIX_W = 28;
   localparam int DIVN_W = 49;
   localparam int DIVD_W = 28;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Operation codes
   localparam logic [1:0] OP_ADVANCE    = 2'd0;
   localparam logic [1:0] OP_SET_TARGET = 2'd1;
   localparam logic [1:0] OP_RESTART    = 2'd2;
   localparam logic [1:0] OP_FAST_FWD   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DOT_RATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PASS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKLOG     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUME_GAP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUME_STEP = 3'd5;

   // Register reset values
   localparam logic [31:0] DOT_RATE_RST    = 32'd65536000;
   localparam logic [31:0] BLANK_RATE_RST  = 32'd13107200;
   localparam logic [6:0]  ROWS_PASS_RST   = 7'd8;
   localparam logic [15:0] BACKLOG_RST     = 16'd64;
   localparam logic [31:0] RESUME_GAP_RST  = 32'd16384;
   localparam logic [31:0] RESUME_STEP_RST = 32'd1092;

   // Controller to datapath commands
   typedef struct packed {
      logic take;
      logic exec;
      logic mul_rate;
      logic mul_gain;
      logic blank;
      logic div1;
      logic div2;
      logic cap1;
      logic cap2;
      logic free;
      logic full;
      logic part;
      logic emit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_adv;
      logic adv_go;
      logic ink;
      logic div_done;
      logic rpp_zero;
      logic q_ge_need;
      logic rsp_free;
   } sts_type;

endpackage

// File: rtl/cpr_chan_if.sv
interface cpr_req_if import cpr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [TIME_W-1:0]   now_time;
   logic                has_ink;
   logic signed [16:0]  goal_rows;
   logic [COL_W-1:0]    goal_width;
   logic signed [16:0]  start_rows;
   modport source(output valid, operation, now_time, has_ink, goal_rows, goal_width,
                  start_rows, input ready);
   modport sink(input valid, operation, now_time, has_ink, goal_rows, goal_width,
                start_rows, output ready);
endinterface

interface cpr_rsp_if import cpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROWS_W-1:0] shown_rows;
   logic [COL_W-1:0]  head_column;
   logic [ROWS_W-1:0] goal_now;
   logic              caught_up;
   logic              left_to_right;
   modport source(output valid, shown_rows, head_column, goal_now, caught_up, left_to_right,
                  input ready);
   modport sink(input valid, shown_rows, head_column, goal_now, caught_up, left_to_right,
                output ready);
endinterface

interface cpr_csr_if import cpr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/cpr_div.sv
module cpr_div import cpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic              done,
   output logic [DIVN_W-1:0] quotient,
   output logic [DIVD_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIVN_W + 1);

   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVD_W:0]   trial;
   logic              fits;

   // One restoring step a cycle, quotient bits shift in behind the dividend
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVN_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVN_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVN_W-2:0], fits};
         rem_in = fits ? DIVD_W'(trial - {1'b0, dvs_ff}) : trial[DIVD_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/cpr_datapath.sv
module cpr_datapath import cpr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [1:0]           req_operation,
   input  logic [TIME_W-1:0]    req_now_time,
   input  logic                 req_has_ink,
   input  logic signed [16:0]   req_goal_rows,
   input  logic [COL_W-1:0]     req_goal_width,
   input  logic signed [16:0]   req_start_rows,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [ROWS_W-1:0]    rsp_shown_rows,
   output logic [COL_W-1:0]     rsp_head_column,
   output logic [ROWS_W-1:0]    rsp_goal_now,
   output logic                 rsp_caught_up,
   output logic                 rsp_left_to_right
);

   localparam logic [COL_W-1:0] MIN_W  = COL_W'(MIN_SWEEP);
   localparam logic [COL_W-1:0] DOTS_W = COL_W'(DOTS_PER_ROW);

   // Configuration
   logic [31:0] dot_rate_ff, dot_rate_in, blank_rate_ff, blank_rate_in;
   logic [6:0]  rpp_ff, rpp_in;
   logic [15:0] backlog_ff, backlog_in;
   logic [31:0] gap_lim_ff, gap_lim_in, step_ff, step_in;

   // Latched item
   logic [1:0]         op_ff;
   logic [TIME_W-1:0]  now_ff;
   logic               ink_ff;
   logic signed [16:0] grows_ff, srows_ff;
   logic [COL_W-1:0]   gwidth_ff;

   // Pacer state
   logic [TIME_W-1:0] prior_ff, prior_in;
   logic              started_ff, started_in;
   logic [REV_W-1:0]  revealed_ff, revealed_in;
   logic [CFIX_W-1:0] column_ff, column_in;
   logic [ROWS_W-1:0] goal_ff, goal_in;
   logic [COL_W-1:0]  span_ff, span_in;
   logic              jump_ff, jump_in, dir_ff, dir_in;

   // Work registers
   logic [31:0]       dt_ff, dt_in;
   logic [63:0]       prod_ff, prod_in;
   logic [DIVN_W-1:0] q1_ff, q1_in;
   logic [DIVD_W-1:0] r1_ff, r1_in;
   logic [16:0]       need_ff, need_in;

   // Result register
   logic              rv_ff, rv_in;
   logic [ROWS_W-1:0] shown_ff, shown_in, gout_ff, gout_in;
   logic [COL_W-1:0]  hcol_ff, hcol_in;
   logic              caught_ff, caught_in, ltr_ff, ltr_in;

   // Combinational helpers
   logic [REV_W-1:0]  goal_fix, remaining, backlog_fix, part_sum;
   logic [CFIX_W-1:0] span_fix;
   logic              caught_fix, jump_now;
   logic [TIME_W-1:0] prior_eff, gap;
   logic [31:0]       dt_val, mul_a, mul_b;
   logic [ROWS_W-1:0] grows_nn, srows_nn, rows_cut;
   logic [COL_W-1:0]  width_cl, col_cut;
   logic [DIVN_W-1:0] blank_sum, col_sum, div_n;
   logic [DIVD_W-1:0] div_d;
   logic              div_start, div_done;
   logic [DIVN_W-1:0] div_q;
   logic [DIVD_W-1:0] div_r;
   logic [16:0]       need_val;
   logic              q_ge_need, q_gt_need;

   cpr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Shared figures
   always_comb begin
      goal_fix    = {goal_ff, 16'd0};
      span_fix    = {span_ff, 16'd0};
      remaining   = goal_fix - revealed_ff;
      backlog_fix = {backlog_ff, 16'd0};
      caught_fix  = revealed_ff >= goal_fix;
      jump_now    = jump_ff || (remaining > backlog_fix);
      prior_eff   = started_ff ? prior_ff : now_ff;
      gap         = (now_ff >= prior_eff) ? (now_ff - prior_eff) : '0;
      dt_val      = (gap > {16'd0, gap_lim_ff}) ? step_ff : gap[31:0];
      grows_nn    = grows_ff[16] ? '0 : grows_ff[15:0];
      srows_nn    = srows_ff[16] ? '0 : srows_ff[15:0];
      if (gwidth_ff < MIN_W) width_cl = MIN_W;
      else if (gwidth_ff > DOTS_W) width_cl = DOTS_W;
      else width_cl = gwidth_ff;
      blank_sum = {17'd0, revealed_ff} + {1'b0, prod_ff[63:16]};
      col_sum   = {21'd0, column_ff} + {1'b0, prod_ff[63:16]};
      part_sum  = revealed_ff + {prod_ff[15:0], 16'd0};
      need_val  = {1'b0, div_q[15:0]}
                + 17'((div_r != '0) || (remaining[15:0] != 16'd0));
      q_ge_need = q1_ff >= {32'd0, need_ff};
      q_gt_need = q1_ff > {32'd0, need_ff};
      rows_cut  = (revealed_ff[31:16] > goal_ff) ? goal_ff : revealed_ff[31:16];
      col_cut   = (column_ff[27:16] > span_ff) ? span_ff : column_ff[27:16];
   end

   // Multiplier and divider operand selection
   always_comb begin
      mul_a = cmd.mul_gain ? q1_ff[31:0] : (ink_ff ? dot_rate_ff : blank_rate_ff);
      mul_b = cmd.mul_gain ? {25'd0, rpp_ff} : dt_ff;
      prod_in   = mul_a * mul_b;
      div_start = cmd.div1 | cmd.div2;
      div_n     = cmd.div2 ? {33'd0, remaining[31:16]} : col_sum;
      div_d     = cmd.div2 ? {21'd0, rpp_ff} : span_fix;
   end

   // Configuration writes
   always_comb begin
      dot_rate_in   = dot_rate_ff;
      blank_rate_in = blank_rate_ff;
      rpp_in        = rpp_ff;
      backlog_in    = backlog_ff;
      gap_lim_in    = gap_lim_ff;
      step_in       = step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DOT_RATE:    dot_rate_in   = csr_data;
            CSR_BLANK_RATE:  blank_rate_in = csr_data;
            CSR_ROWS_PASS:   rpp_in        = csr_data[6:0];
            CSR_BACKLOG:     backlog_in    = csr_data[15:0];
            CSR_RESUME_GAP:  gap_lim_in    = csr_data;
            CSR_RESUME_STEP: step_in       = csr_data;
            default:         ;
         endcase
      end
   end

   // Pacer state update
   always_comb begin
      prior_in    = prior_ff;
      started_in  = started_ff;
      revealed_in = revealed_ff;
      column_in   = column_ff;
      goal_in     = goal_ff;
      span_in     = span_ff;
      jump_in     = jump_ff;
      dir_in      = dir_ff;
      dt_in       = dt_ff;
      q1_in       = q1_ff;
      r1_in       = r1_ff;
      need_in     = need_ff;
      if (cmd.exec) begin
         case (op_ff)
            OP_ADVANCE: begin
               prior_in   = now_ff;
               started_in = 1'b1;
               dt_in      = dt_val;
               if (caught_fix) begin
                  revealed_in = goal_fix;
               end else if (jump_now) begin
                  revealed_in = goal_fix;
                  column_in   = '0;
                  jump_in     = 1'b0;
               end
            end
            OP_SET_TARGET: begin
               goal_in = grows_nn;
               span_in = width_cl;
               if (column_ff > {width_cl, 16'd0}) column_in = {width_cl, 16'd0};
               if (revealed_ff > {grows_nn, 16'd0}) begin
                  revealed_in = {grows_nn, 16'd0};
                  column_in   = '0;
               end
            end
            OP_RESTART: begin
               prior_in    = now_ff;
               revealed_in = {srows_nn, 16'd0};
               column_in   = '0;
               started_in  = 1'b1;
               jump_in     = 1'b0;
               dir_in      = 1'b1;
               if (goal_ff < srows_nn) goal_in = srows_nn;
            end
            OP_FAST_FWD: jump_in = 1'b1;
            default:     ;
         endcase
      end
      if (cmd.blank) begin
         revealed_in = (blank_sum < {17'd0, goal_fix}) ? blank_sum[REV_W-1:0] : goal_fix;
      end
      if (cmd.cap1) begin
         q1_in = div_q;
         r1_in = div_r;
      end
      if (cmd.cap2) need_in = need_val;
      // No rows per pass: keep the remainder and flip once per pass
      if (cmd.free) begin
         column_in = r1_ff;
         dir_in    = dir_ff ^ q1_ff[0];
      end
      // Enough passes to reach the target
      if (cmd.full) begin
         revealed_in = goal_fix;
         column_in   = q_gt_need ? span_fix : r1_ff;
         dir_in      = dir_ff ^ need_ff[0];
      end
      if (cmd.part) begin
         revealed_in = part_sum;
         column_in   = r1_ff;
         dir_in      = dir_ff ^ q1_ff[0];
      end
   end

   // Result register: load on emit, drop on transfer
   always_comb begin
      rv_in     = rv_ff;
      shown_in  = shown_ff;
      hcol_in   = hcol_ff;
      gout_in   = gout_ff;
      caught_in = caught_ff;
      ltr_in    = ltr_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (cmd.emit) begin
         rv_in     = 1'b1;
         shown_in  = rows_cut;
         hcol_in   = col_cut;
         gout_in   = goal_ff;
         caught_in = rows_cut >= goal_ff;
         ltr_in    = dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= (cmd.mul_rate || cmd.mul_gain) ? prod_in : prod_ff;
      dt_ff   <= dt_in;
      q1_ff   <= q1_in;
      r1_ff   <= r1_in;
      need_ff <= need_in;
      shown_ff  <= shown_in;
      hcol_ff   <= hcol_in;
      gout_ff   <= gout_in;
      caught_ff <= caught_in;
      ltr_ff    <= ltr_in;
      if (cmd.take) begin
         op_ff     <= req_operation;
         now_ff    <= req_now_time;
         ink_ff    <= req_has_ink;
         grows_ff  <= req_goal_rows;
         gwidth_ff <= req_goal_width;
         srows_ff  <= req_start_rows;
      end
      if (reset) begin
         dot_rate_ff   <= DOT_RATE_RST;
         blank_rate_ff <= BLANK_RATE_RST;
         rpp_ff        <= ROWS_PASS_RST;
         backlog_ff    <= BACKLOG_RST;
         gap_lim_ff    <= RESUME_GAP_RST;
         step_ff       <= RESUME_STEP_RST;
         prior_ff      <= '0;
         started_ff    <= 1'b0;
         revealed_ff   <= '0;
         column_ff     <= '0;
         goal_ff       <= '0;
         span_ff       <= DOTS_W;
         jump_ff       <= 1'b0;
         dir_ff        <= 1'b1;
         rv_ff         <= 1'b0;
      end else begin
         dot_rate_ff   <= dot_rate_in;
         blank_rate_ff <= blank_rate_in;
         rpp_ff        <= rpp_in;
         backlog_ff    <= backlog_in;
         gap_lim_ff    <= gap_lim_in;
         step_ff       <= step_in;
         prior_ff      <= prior_in;
         started_ff    <= started_in;
         revealed_ff   <= revealed_in;
         column_ff     <= column_in;
         goal_ff       <= goal_in;
         span_ff       <= span_in;
         jump_ff       <= jump_in;
         dir_ff        <= dir_in;
         rv_ff         <= rv_in;
      end
   end

   always_comb begin
      sts.is_adv    = op_ff == OP_ADVANCE;
      sts.adv_go    = !caught_fix && !jump_now;
      sts.ink       = ink_ff;
      sts.div_done  = div_done;
      sts.rpp_zero  = rpp_ff == 7'd0;
      sts.q_ge_need = q_ge_need;
      sts.rsp_free  = !rv_ff || rsp_ready;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_shown_rows    = shown_ff;
   assign rsp_head_column   = hcol_ff;
   assign rsp_goal_now      = gout_ff;
   assign rsp_caught_up     = caught_ff;
   assign rsp_left_to_right = ltr_ff;

endmodule

// File: rtl/cpr_ctrl.sv
module cpr_ctrl import cpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXEC  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_BLANK = 4'd3;
   localparam logic [3:0] ST_COL   = 4'd4;
   localparam logic [3:0] ST_DIV1  = 4'd5;
   localparam logic [3:0] ST_CHK1  = 4'd6;
   localparam logic [3:0] ST_DIV2  = 4'd7;
   localparam logic [3:0] ST_CHK2  = 4'd8;
   localparam logic [3:0] ST_GAIN  = 4'd9;
   localparam logic [3:0] ST_EMIT  = 4'd10;

   logic [3:0] state_ff, state_in;

   // Sequence one item through the datapath
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.is_adv && sts.adv_go) ? ST_MUL : ST_EMIT;
         end
         ST_MUL: begin
            cmd.mul_rate = 1'b1;
            state_in     = sts.ink ? ST_COL : ST_BLANK;
         end
         ST_BLANK: begin
            cmd.blank = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_COL: begin
            cmd.div1 = 1'b1;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (sts.div_done) begin
               cmd.cap1 = 1'b1;
               state_in = ST_CHK1;
            end
         end
         ST_CHK1: begin
            if (sts.rpp_zero) begin
               cmd.free = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.div2 = 1'b1;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (sts.div_done) begin
               cmd.cap2 = 1'b1;
               state_in = ST_CHK2;
            end
         end
         ST_CHK2: begin
            if (sts.q_ge_need) begin
               cmd.full = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.mul_gain = 1'b1;
               state_in     = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.part = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// File: rtl/print_carriage_reveal_pacer_top.sv
// Print carriage reveal pacer.
// req_chan carries one operation (advance, set target, restart, fast forward)
// per transfer; rsp_chan returns exactly one status item for every operation,
// taken after the update. csr_chan writes the six rate and limit registers and
// is always ready; write it only while no operation is in flight.
// Set target, restart, fast forward and an advance that is caught up or jumps
// go from the update straight to the result register; an advance over a blank
// band adds a rate multiply and a blank step. An inked advance multiplies by
// the rate, then runs the shared one-bit-a-cycle divider for the column and,
// with rows per pass set, for the passes that the target needs; if fewer
// passes are made, a gain multiply and a partial step follow.
// One item is worked at a time; req_chan is ready only while the sequencer is
// idle, from the cycle after the previous result is loaded. A finished result
// sits in the output register until taken; a stalled receiver holds the next
// result in the sequencer and with it the request after that.
// Reset (synchronous) clears the pacer state, loads the register defaults and
// drops any result waiting on rsp_chan.
module print_carriage_reveal_pacer_top import cpr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cpr_req_if.sink   req_chan,
   cpr_rsp_if.source rsp_chan,
   cpr_csr_if.sink   csr_chan
);

   cmd_type cmd;
   sts_type sts;

   assign csr_chan.ready = 1'b1;

   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cpr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_chan.operation),
      .req_now_time      (req_chan.now_time),
      .req_has_ink       (req_chan.has_ink),
      .req_goal_rows     (req_chan.goal_rows),
      .req_goal_width    (req_chan.goal_width),
      .req_start_rows    (req_chan.start_rows),
      .csr_valid         (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_shown_rows    (rsp_chan.shown_rows),
      .rsp_head_column   (rsp_chan.head_column),
      .rsp_goal_now      (rsp_chan.goal_now),
      .rsp_caught_up     (rsp_chan.caught_up),
      .rsp_left_to_right (rsp_chan.left_to_right)
   );

endmodule

// File: rtl/cpr_checker.sv
`include "assert_macros.svh"

module cpr_checker import cpr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ROWS_W-1:0] shown_rows,
   input logic [ROWS_W-1:0] goal_now,
   input logic              caught_up
);

   // Hold a result until it is taken
   `CPR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // One item at a time: no request taken straight after a transfer
   `CPR_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   // Revealed rows never pass the target and caught_up tracks them
   `CPR_ASSERT_IMP(a_rows_in_range, rsp_valid,
                   (shown_rows <= goal_now) && (caught_up == (shown_rows == goal_now)))
   // A request that is taken cannot come back as a result in the next cycle
   `CPR_ASSERT_NXT(a_no_instant_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid)

endmodule

bind print_carriage_reveal_pacer_top cpr_checker u_cpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .shown_rows (rsp_chan.shown_rows),
   .goal_now   (rsp_chan.goal_now),
   .caught_up  (rsp_chan.caught_up)
);
